// ===== design/prqs_pkg.sv =====
// Shared sizes, codes and field widths of the priority ready-queue scheduler.
package prqs_pkg;

    localparam int LEVELS  = 32;
    localparam int THREADS = 64;

    localparam int TID_W  = $clog2(THREADS);
    localparam int LVL_W  = $clog2(LEVELS);
    localparam int LINK_W = TID_W + 1;
    localparam int REQ_W  = 2;
    localparam int STAT_W = 2;

    // Link value that marks the end of a list
    localparam logic [LINK_W-1:0] NIL = LINK_W'(THREADS);

    // Request codes
    localparam logic [REQ_W-1:0] REQ_ENQ    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STAT_W-1:0] ST_REJECT    = 2'd3;

endpackage

// ===== design/prqs_ram.sv =====
// Generic single write port RAM with one registered read port.
module prqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== design/priority_ready_queue_scheduler.sv =====
// Top level of the bitmap priority ready-queue scheduler.
//
//  channel | handshake              | fields
//  --------+------------------------+--------------------------------------
//  request | in_valid / in_stall    | req_type, thread_id, priority_req
//  result  | out_valid / out_stall  | popped_thread, status
//
// Enqueue reads the level's head and tail, appends the entry, links the old tail
// and then loads the result register; pop reads the level and the head's link.
// Remove walks its level's list, one read of the link memory per list step, until
// it finds the thread or, on a miss, reaches the end of the level. Rejected or
// empty requests skip the memory steps and go straight to loading the result
// register. One item is in progress at a time; the next is taken back in idle.
// Reset clears the ready bitmap and the queued flags; the head/tail and link
// memories need no clearing, a level's head and tail count only while its bit
// is set. A stalled result is held in the output register while the next item
// is accepted; a further result waits until that register is free.
module priority_ready_queue_scheduler (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [prqs_pkg::REQ_W-1:0]   req_type,
    input  logic [prqs_pkg::TID_W-1:0]   thread_id,
    input  logic [prqs_pkg::LVL_W-1:0]   priority_req,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [prqs_pkg::TID_W-1:0]   popped_thread,
    output logic [prqs_pkg::STAT_W-1:0]  status
);
    import prqs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LVLRD,
        S_ENQ2,
        S_POP2,
        S_WALK,
        S_FIN
    } state_t;

    state_t              state_reg,      state_next;
    logic [REQ_W-1:0]    req_reg,        req_next;
    logic [TID_W-1:0]    tid_reg,        tid_next;
    logic [LVL_W-1:0]    lvl_reg,        lvl_next;
    logic                had_reg,        had_next;
    logic [TID_W-1:0]    head_reg,       head_next;
    logic [TID_W-1:0]    tail_reg,       tail_next;
    logic [TID_W-1:0]    cur_reg,        cur_next;
    logic [LINK_W-1:0]   prev_reg,       prev_next;
    logic [TID_W-1:0]    res_thread_reg, res_thread_next;
    logic [STAT_W-1:0]   res_status_reg, res_status_next;
    logic [LEVELS-1:0]   mask_reg,       mask_next;
    logic [THREADS-1:0]  queued_reg,     queued_next;
    logic                out_valid_reg,  out_valid_next;
    logic [TID_W-1:0]    out_thread_reg, out_thread_next;
    logic [STAT_W-1:0]   out_status_reg, out_status_next;

    // Memory ports
    logic                link_we;
    logic [TID_W-1:0]    link_waddr;
    logic [LINK_W-1:0]   link_wdata;
    logic [TID_W-1:0]    link_raddr;
    logic [LINK_W-1:0]   link_rdata;
    logic                level_we;
    logic [LVL_W-1:0]    level_waddr;
    logic [2*TID_W-1:0]  level_wdata;
    logic [LVL_W-1:0]    level_raddr;
    logic [2*TID_W-1:0]  level_rdata;

    logic [LVL_W-1:0]    ffs_lvl;
    logic [TID_W-1:0]    rd_head;
    logic                link_nil;
    logic [LINK_W-1:0]   nx;
    logic                prev_ok;
    logic [LINK_W-1:0]   new_head;
    logic [LINK_W-1:0]   new_tail;

    // Per-thread next links
    prqs_ram #(
        .WIDTH (LINK_W),
        .DEPTH (THREADS)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    // Per-level head and tail, valid while the level's ready bit is set
    prqs_ram #(
        .WIDTH (2 * TID_W),
        .DEPTH (LEVELS)
    ) u_level_ram (
        .clk   (clk),
        .we    (level_we),
        .waddr (level_waddr),
        .wdata (level_wdata),
        .raddr (level_raddr),
        .rdata (level_rdata)
    );

    // Find the most urgent ready level
    always_comb
    begin
        ffs_lvl = '0;
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                ffs_lvl = LVL_W'(i);
            end
        end
    end

    // Decode memory read data
    assign rd_head  = level_rdata[2*TID_W-1:TID_W];
    assign link_nil = (link_rdata >= NIL);
    assign nx       = link_nil ? NIL : link_rdata;
    assign prev_ok  = (prev_reg < NIL);
    assign new_head = prev_ok ? {1'b0, head_reg} : nx;
    assign new_tail = (tail_reg == cur_reg) ? prev_reg : {1'b0, tail_reg};

    // Read addresses
    assign level_raddr = (req_type == REQ_POP) ? ffs_lvl : priority_req;
    assign link_raddr  = (state_reg == S_LVLRD) ? rd_head : link_rdata[TID_W-1:0];

    // Sequence one item through the memories
    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        tid_next        = tid_reg;
        lvl_next        = lvl_reg;
        had_next        = had_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        res_thread_next = res_thread_reg;
        res_status_next = res_status_reg;
        mask_next       = mask_reg;
        queued_next     = queued_reg;
        out_thread_next = out_thread_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg;
        link_we         = 1'b0;
        link_waddr      = tid_reg;
        link_wdata      = NIL;
        level_we        = 1'b0;
        level_waddr     = lvl_reg;
        level_wdata     = {head_reg, tail_reg};

        // Drop a result once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next        = req_type;
                    tid_next        = thread_id;
                    lvl_next        = level_raddr;
                    had_next        = mask_reg[level_raddr];
                    res_thread_next = '0;
                    state_next      = S_LVLRD;
                    case (req_type)
                        REQ_ENQ:
                        begin
                            if (queued_reg[thread_id])
                            begin
                                res_status_next = ST_REJECT;
                                state_next      = S_FIN;
                            end
                        end
                        REQ_POP:
                        begin
                            if (mask_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                                state_next      = S_FIN;
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (!queued_reg[thread_id] || !mask_reg[priority_req])
                            begin
                                res_status_next = ST_NOT_FOUND;
                                state_next      = S_FIN;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_REJECT;
                            state_next      = S_FIN;
                        end
                    endcase
                end
            end

            S_LVLRD:
            begin
                head_next = rd_head;
                tail_next = level_rdata[TID_W-1:0];
                case (req_reg)
                    REQ_ENQ:
                    begin
                        // Terminate the new entry and append it to the level
                        link_we     = 1'b1;
                        link_waddr  = tid_reg;
                        link_wdata  = NIL;
                        level_we    = 1'b1;
                        level_wdata = {(had_reg ? rd_head : tid_reg), tid_reg};
                        mask_next[lvl_reg]   = 1'b1;
                        queued_next[tid_reg] = 1'b1;
                        state_next  = S_ENQ2;
                    end
                    REQ_POP:
                    begin
                        cur_next   = rd_head;
                        state_next = S_POP2;
                    end
                    default:
                    begin
                        cur_next   = rd_head;
                        prev_next  = NIL;
                        state_next = S_WALK;
                    end
                endcase
            end

            S_ENQ2:
            begin
                // Link the old tail to the new entry
                if (had_reg)
                begin
                    link_we    = 1'b1;
                    link_waddr = tail_reg;
                    link_wdata = {1'b0, tid_reg};
                end
                res_status_next = ST_OK;
                state_next      = S_FIN;
            end

            S_POP2:
            begin
                // Advance the head past the popped thread
                queued_next[cur_reg] = 1'b0;
                res_thread_next      = cur_reg;
                res_status_next      = ST_OK;
                if (link_nil)
                begin
                    mask_next[lvl_reg] = 1'b0;
                end
                else
                begin
                    level_we    = 1'b1;
                    level_wdata = {link_rdata[TID_W-1:0], tail_reg};
                end
                state_next = S_FIN;
            end

            S_WALK:
            begin
                if (cur_reg == tid_reg)
                begin
                    // Unlink the thread and repair head and tail
                    if (prev_ok)
                    begin
                        link_we    = 1'b1;
                        link_waddr = prev_reg[TID_W-1:0];
                        link_wdata = nx;
                    end
                    queued_next[cur_reg] = 1'b0;
                    if (new_head == NIL)
                    begin
                        mask_next[lvl_reg] = 1'b0;
                    end
                    else
                    begin
                        level_we    = 1'b1;
                        level_wdata = {new_head[TID_W-1:0], new_tail[TID_W-1:0]};
                    end
                    res_status_next = ST_OK;
                    state_next      = S_FIN;
                end
                else if (link_nil)
                begin
                    res_status_next = ST_NOT_FOUND;
                    state_next      = S_FIN;
                end
                else
                begin
                    prev_next = {1'b0, cur_reg};
                    cur_next  = link_rdata[TID_W-1:0];
                end
            end

            S_FIN:
            begin
                // Hand the result over once the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_thread_next = res_thread_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            req_reg        <= '0;
            tid_reg        <= '0;
            lvl_reg        <= '0;
            had_reg        <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            cur_reg        <= '0;
            prev_reg       <= NIL;
            res_thread_reg <= '0;
            res_status_reg <= ST_OK;
            mask_reg       <= '0;
            queued_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_thread_reg <= '0;
            out_status_reg <= ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            req_reg        <= req_next;
            tid_reg        <= tid_next;
            lvl_reg        <= lvl_next;
            had_reg        <= had_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            cur_reg        <= cur_next;
            prev_reg       <= prev_next;
            res_thread_reg <= res_thread_next;
            res_status_reg <= res_status_next;
            mask_reg       <= mask_next;
            queued_reg     <= queued_next;
            out_valid_reg  <= out_valid_next;
            out_thread_reg <= out_thread_next;
            out_status_reg <= out_status_next;
        end
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign popped_thread = out_thread_reg;
    assign status        = out_status_reg;

    // A new result appears only when the sequencer hands one over
    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_FIN))
        else $error("result appeared without a finished item");

    // A popped thread is no longer marked as queued
    a_pop_clears_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP2) |=> !queued_reg[$past(cur_reg)])
        else $error("popped thread still marked as queued");

    // After an append the level is ready and the thread is queued
    a_enq_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ENQ2) |-> (mask_reg[lvl_reg] && queued_reg[tid_reg]))
        else $error("enqueued thread or level not marked");

endmodule

// ===== verif/priority_ready_queue_scheduler_test.sv =====
// Self-checking testbench for the bitmap priority ready-queue scheduler.
module priority_ready_queue_scheduler_test;
    import prqs_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 100;
    localparam int RANDOM_PER_PHASE = 440;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [TID_W-1:0]  thread;
        logic [STAT_W-1:0] stat;
    } sched_result_t;

    // Ready-queue predictor and store of the results still owed by the block
    class ready_queue_tracker;
        logic [LINK_W-1:0] link_next [THREADS];
        bit                queued [THREADS];
        logic [LVL_W-1:0]  level_of [THREADS];
        logic [LINK_W-1:0] head [LEVELS];
        logic [LINK_W-1:0] tail [LEVELS];
        logic [LEVELS-1:0] ready;
        sched_result_t     pending_results [$];
        int                mismatches;

        function new();
            for (int i = 0; i < THREADS; i++)
            begin
                link_next[i] = NIL;
                queued[i] = 1'b0;
                level_of[i] = '0;
            end
            for (int i = 0; i < LEVELS; i++)
            begin
                head[i] = NIL;
                tail[i] = NIL;
            end
            ready = '0;
            mismatches = 0;
        endfunction

        function int queued_count();
            int n;
            n = 0;
            for (int i = 0; i < THREADS; i++)
                n += queued[i];
            return n;
        endfunction

        // Pick a thread whose queued flag matches, scanning from a random start
        function logic [TID_W-1:0] pick_thread(bit want_queued);
            int start;
            start = $urandom_range(THREADS - 1);
            for (int i = 0; i < THREADS; i++)
                if (queued[(start + i) % THREADS] == want_queued)
                    return TID_W'((start + i) % THREADS);
            return TID_W'(start);
        endfunction

        function logic [STAT_W-1:0] predict_enqueue(logic [TID_W-1:0] tid,
                                                    logic [LVL_W-1:0] lvl);
            if (queued[tid])
                return ST_REJECT;
            link_next[tid] = NIL;
            if (tail[lvl] < THREADS)
                link_next[tail[lvl][TID_W-1:0]] = LINK_W'(tid);
            else
                head[lvl] = LINK_W'(tid);
            tail[lvl] = LINK_W'(tid);
            queued[tid] = 1'b1;
            level_of[tid] = lvl;
            ready[lvl] = 1'b1;
            return ST_OK;
        endfunction

        function logic [STAT_W-1:0] pop_best(output logic [TID_W-1:0] who);
            int lvl;
            logic [LINK_W-1:0] h;
            who = '0;
            lvl = 0;
            while (lvl < LEVELS && !ready[lvl])
                lvl++;
            if (lvl >= LEVELS)
                return ST_EMPTY;
            h = head[lvl];
            if (h >= THREADS)
            begin
                ready[lvl] = 1'b0;
                return ST_EMPTY;
            end
            head[lvl] = link_next[h[TID_W-1:0]];
            if (head[lvl] >= THREADS)
            begin
                head[lvl] = NIL;
                tail[lvl] = NIL;
                ready[lvl] = 1'b0;
            end
            queued[h[TID_W-1:0]] = 1'b0;
            who = h[TID_W-1:0];
            return ST_OK;
        endfunction

        // Walk the level's list, bounded to one step per thread
        function logic [STAT_W-1:0] predict_remove(logic [TID_W-1:0] tid,
                                                   logic [LVL_W-1:0] lvl);
            logic [LINK_W-1:0] prev;
            logic [LINK_W-1:0] cur;
            logic [LINK_W-1:0] nx;
            prev = NIL;
            cur = head[lvl];
            for (int steps = 0; steps < THREADS && cur < THREADS; steps++)
            begin
                if (cur == LINK_W'(tid))
                begin
                    nx = link_next[cur[TID_W-1:0]];
                    if (nx >= THREADS)
                        nx = NIL;
                    if (prev < THREADS)
                        link_next[prev[TID_W-1:0]] = nx;
                    else
                        head[lvl] = nx;
                    if (tail[lvl] == cur)
                        tail[lvl] = prev;
                    queued[tid] = 1'b0;
                    if (head[lvl] >= THREADS)
                        ready[lvl] = 1'b0;
                    return ST_OK;
                end
                prev = cur;
                cur = link_next[cur[TID_W-1:0]];
            end
            return ST_NOT_FOUND;
        endfunction

        // Advance the predicted state by one accepted item and hold its result
        function void note_request(logic [REQ_W-1:0] req, logic [TID_W-1:0] tid,
                                   logic [LVL_W-1:0] lvl);
            sched_result_t r;
            r.thread = '0;
            case (req)
                REQ_ENQ:    r.stat = predict_enqueue(tid, lvl);
                REQ_POP:    r.stat = pop_best(r.thread);
                REQ_REMOVE: r.stat = predict_remove(tid, lvl);
                default:    r.stat = ST_REJECT;
            endcase
            pending_results.insert(pending_results.size(), r);
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        task check_result(logic [TID_W-1:0] thread, logic [STAT_W-1:0] stat);
            sched_result_t exp_r;
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result thread %0d status %0d",
                                          thread, stat));
                return;
            end
            exp_r = pending_results[0];
            pending_results.delete(0);
            if (stat !== exp_r.stat)
                report_mismatch($sformatf("status %0d, expected %0d", stat, exp_r.stat));
            if (thread !== exp_r.thread)
                report_mismatch($sformatf("popped_thread %0d, expected %0d",
                                          thread, exp_r.thread));
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [REQ_W-1:0]   req_type;
    logic [TID_W-1:0]   thread_id;
    logic [LVL_W-1:0]   priority_req;
    logic               out_valid;
    logic               out_stall;
    logic [TID_W-1:0]   popped_thread;
    logic [STAT_W-1:0]  status;

    ready_queue_tracker sched = new();
    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_request;
    int cycle_count = 0;

    priority_ready_queue_scheduler dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .thread_id     (thread_id),
        .priority_req  (priority_req),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .popped_thread (popped_thread),
        .status        (status)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // Give up well beyond the slowest correct run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Offer one item, after a random gap, and hold it until it is accepted
    task automatic send_request(logic [REQ_W-1:0] req, logic [TID_W-1:0] tid,
                                logic [LVL_W-1:0] lvl);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        thread_id <= tid;
        priority_req <= lvl;
        do
            @(posedge clk);
        while (in_stall);
        sched.note_request(req, tid, lvl);
    endtask

    // Drop valid and wait until every owed result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sched.pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Mostly well-formed traffic on a few crowded levels, with some noise
    task automatic send_random_request();
        int pick;
        int live;
        int enq_share;
        logic [TID_W-1:0] tid;
        logic [LVL_W-1:0] lvl;
        pick = $urandom_range(99);
        live = sched.queued_count();
        enq_share = (live > 48) ? 25 : 45;
        tid = TID_W'($urandom_range(THREADS - 1));
        lvl = LVL_W'($urandom_range(LEVELS - 1));
        if (pick < enq_share)
        begin
            if (live < THREADS)
                tid = sched.pick_thread(1'b0);
            if ($urandom_range(3) != 0)
                lvl = LVL_W'($urandom_range(3));
            send_request(REQ_ENQ, tid, lvl);
        end
        else if (pick < 72)
            send_request(REQ_POP, tid, lvl);
        else if (pick < 90)
        begin
            if (live > 0 && $urandom_range(3) != 0)
            begin
                tid = sched.pick_thread(1'b1);
                lvl = sched.level_of[tid];
            end
            send_request(REQ_REMOVE, tid, lvl);
        end
        else if (pick < 95)
            send_request(REQ_ENQ, tid, lvl);
        else
            send_request(REQ_UNUSED, tid, lvl);
    endtask

    // Result side: check accepted results and stall at random or for a long hold
    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                sched.check_result(popped_thread, status);
            if (hold_request != 0 && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= (receiver_stall_pct != 0 &&
                              $urandom_range(99) < receiver_stall_pct);
        end
    end

    initial
    begin
        in_valid = 1'b0;
        req_type = REQ_ENQ;
        thread_id = '0;
        priority_req = '0;
        hold_request = 0;
        sender_idle_pct = 13;
        receiver_stall_pct = 53;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty scheduler: pop and remove find nothing
        send_request(REQ_POP, 6'd63, 5'd31);
        send_request(REQ_REMOVE, 6'd0, 5'd0);
        // Extreme threads on extreme levels, then a repeated enqueue
        send_request(REQ_ENQ, 6'd0, 5'd31);
        send_request(REQ_ENQ, 6'd63, 5'd0);
        send_request(REQ_ENQ, 6'd63, 5'd5);
        send_request(REQ_UNUSED, 6'd63, 5'd31);
        // Build a list of four on the last level
        send_request(REQ_ENQ, 6'd21, 5'd31);
        send_request(REQ_ENQ, 6'd42, 5'd31);
        send_request(REQ_ENQ, 6'd5, 5'd31);
        // Remove from the wrong level and of an unqueued thread
        send_request(REQ_REMOVE, 6'd21, 5'd0);
        send_request(REQ_REMOVE, 6'd7, 5'd31);
        // Unlink middle, tail and head
        send_request(REQ_REMOVE, 6'd21, 5'd31);
        send_request(REQ_REMOVE, 6'd5, 5'd31);
        send_request(REQ_REMOVE, 6'd0, 5'd31);
        send_request(REQ_REMOVE, 6'd0, 5'd31);
        // Pop urgent level first, then the rest, then nothing left
        send_request(REQ_POP, 6'd0, 5'd0);
        send_request(REQ_POP, 6'd42, 5'd10);
        send_request(REQ_POP, 6'd0, 5'd0);
        wait_drained();

        // Random traffic with the sender idling lightly, receiver heavily
        for (int i = 0; i < RANDOM_PER_PHASE; i++)
            send_random_request();
        wait_drained();

        sender_idle_pct = 53;
        receiver_stall_pct = 13;
        for (int i = 0; i < RANDOM_PER_PHASE; i++)
            send_random_request();
        wait_drained();

        // No idling; open with a long receiver hold so the block backs up
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_request = 1;
        for (int i = 0; i < RANDOM_PER_PHASE; i++)
            send_random_request();
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sched.pending_results.size() != 0)
            sched.report_mismatch("results still owed at the end");
        if (sched.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
